>>> rtl/salru_pkg.sv
// ----------------------------------------------------------------------------
// salru_pkg
// shared types, codes and helpers of the set-associative lru cache model
// ----------------------------------------------------------------------------
package salru_pkg;

    // default sizes of the cache
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_STAMP_WIDTH  = 32;

    // fixed field widths
    localparam int ADDR_W  = 64;
    localparam int TAG_W   = 64;
    localparam int TOTAL_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // access kinds
    localparam logic [1:0] OP_FETCH  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_STORE  = 2'd2;
    localparam logic [1:0] OP_MODIFY = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] address;
    } t_access;

    typedef struct packed {
        logic [1:0]         access_hits;
        logic               access_miss;
        logic               access_eviction;
        logic [TOTAL_W-1:0] total_hits;
        logic [TOTAL_W-1:0] total_misses;
        logic [TOTAL_W-1:0] total_evictions;
    } t_result;

    // outcome of one tag lookup
    typedef struct packed {
        logic hit;
        logic miss;
        logic evict;
    } t_look_stat;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + (TOTAL_W+1)'(b);
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

endpackage

>>> rtl/set_assoc_lru_cache_model.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// hit/miss/eviction model of a set-associative cache with lru replacement
// ----------------------------------------------------------------------------
// After reset the block sweeps its set memory to zero with busy high;
// configuration writes are taken during the sweep. A word is taken when
// start is high and busy is low. For an instruction fetch the result
// strobes in the next cycle and busy stays low. A load, store or modify
// holds busy high through the states S_LOOK, S_MINS and S_PICK, and its
// result strobes in the cycle after S_PICK, so the next word can be taken
// at the earliest in that strobe cycle; these steps make up the single
// read-modify-write of the set row: memory read, tag compare and row
// update, oldest-stamp search, write-back. The result is on o_result for
// one cycle with o_valid high; there is no way to hold it off, so the
// receiver must take it then. Totals saturate at all ones.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model
    import salru_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int STAMP_WIDTH  = DEF_STAMP_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_access               i_access,
    output logic                  o_valid,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    // row layout, low to high: valids, tags, stamps, victim way
    localparam int TAG_LO   = MAX_WAYS;
    localparam int STAMP_LO = TAG_LO + MAX_WAYS * TAG_W;
    localparam int VIC_LO   = STAMP_LO + MAX_WAYS * STAMP_WIDTH;
    localparam int ROW_W    = VIC_LO + WAY_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_MINS,
        S_PICK
    } t_state;

    t_state r_state;

    // configuration
    logic [2:0] r_set_bits;
    logic [3:0] r_ways;
    logic [3:0] r_off_bits;

    // running state
    logic [STAMP_WIDTH-1:0] r_stamp_ctr;
    logic [TOTAL_W-1:0]     r_hit_total;
    logic [TOTAL_W-1:0]     r_miss_total;
    logic [TOTAL_W-1:0]     r_evict_total;
    logic [SET_W-1:0]       r_clr_addr;

    // item in flight
    logic [1:0]       r_op;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;

    // updated row held for the victim search and write-back
    logic [MAX_WAYS-1:0]                  r_valids;
    logic [MAX_WAYS-1:0][TAG_W-1:0]       r_tags;
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] r_stamps;
    logic [WAY_W-1:0]                     r_victim;
    t_look_stat                           r_stat;

    logic    r_out_valid;
    t_result r_result;

    // address split
    logic [2:0]        s_eff;
    logic [3:0]        ways_eff;
    logic [ADDR_W-1:0] shifted;
    logic [SET_W-1:0]  set_mask;
    logic [SET_W-1:0]  n_set;
    logic [TAG_W-1:0]  n_tag;
    logic [MAX_WAYS-1:0] active;

    // memory side
    logic             take;
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] rd_row;

    // lookup results
    logic [MAX_WAYS-1:0]                  lk_valids;
    logic [MAX_WAYS-1:0][TAG_W-1:0]       lk_tags;
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] lk_stamps;
    logic [WAY_W-1:0]                     lk_victim;
    t_look_stat                           lk_stat;
    logic [WAY_W-1:0]                     best_way;

    // totals after this access
    logic [1:0]         n_hits;
    logic [TOTAL_W-1:0] n_hit_total;
    logic [TOTAL_W-1:0] n_miss_total;
    logic [TOTAL_W-1:0] n_evict_total;

    always_comb begin
        // set bits beyond the memory act as the maximum
        s_eff = (32'(r_set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : r_set_bits;
        // associativity clamped to 1..MAX_WAYS
        if (r_ways == '0) begin
            ways_eff = 4'd1;
        end else if (32'(r_ways) > MAX_WAYS) begin
            ways_eff = 4'(MAX_WAYS);
        end else begin
            ways_eff = r_ways;
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            active[w] = (32'(w) < 32'(ways_eff));
        end

        shifted  = i_access.address >> r_off_bits;
        set_mask = SET_W'((64'd1 << s_eff) - 64'd1);
        n_set    = shifted[SET_W-1:0] & set_mask;
        n_tag    = shifted >> s_eff;
    end

    assign busy = (r_state != S_IDLE);
    assign take = start && !busy;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_set;
        ram_wdata = {best_way, r_stamps, r_tags, r_valids};
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_PICK: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    salru_ram #(
        .AW (SET_W),
        .DW (ROW_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (take && (i_access.operation != OP_FETCH)),
        .i_raddr (n_set),
        .o_rdata (rd_row)
    );

    salru_lookup #(
        .MAX_WAYS    (MAX_WAYS),
        .STAMP_WIDTH (STAMP_WIDTH),
        .WAY_W       (WAY_W)
    ) u_lookup (
        .i_valids (rd_row[MAX_WAYS-1:0]),
        .i_tags   (rd_row[STAMP_LO-1:TAG_LO]),
        .i_stamps (rd_row[VIC_LO-1:STAMP_LO]),
        .i_victim (rd_row[ROW_W-1:VIC_LO]),
        .i_active (active),
        .i_ways   (ways_eff),
        .i_tag    (r_tag),
        .i_stamp  (r_stamp_ctr),
        .o_valids (lk_valids),
        .o_tags   (lk_tags),
        .o_stamps (lk_stamps),
        .o_victim (lk_victim),
        .o_stat   (lk_stat)
    );

    salru_victim #(
        .MAX_WAYS    (MAX_WAYS),
        .STAMP_WIDTH (STAMP_WIDTH),
        .WAY_W       (WAY_W)
    ) u_victim (
        .i_clk    (i_clk),
        .i_load   (r_state == S_MINS),
        .i_stamps (r_stamps),
        .i_active (active),
        .i_victim (r_victim),
        .o_best   (best_way)
    );

    // a modify adds the store lookup, which always hits
    always_comb begin
        n_hits        = {1'b0, r_stat.hit} + {1'b0, (r_op == OP_MODIFY)};
        n_hit_total   = sat_add(r_hit_total, n_hits);
        n_miss_total  = sat_add(r_miss_total, {1'b0, r_stat.miss});
        n_evict_total = sat_add(r_evict_total, {1'b0, r_stat.evict});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_set_bits    <= '0;
            r_ways        <= 4'd1;
            r_off_bits    <= '0;
            r_stamp_ctr   <= '0;
            r_hit_total   <= '0;
            r_miss_total  <= '0;
            r_evict_total <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;

            // register writes, taken in any state
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SET_BITS:    r_set_bits <= i_cfg_data[2:0];
                    CFG_WAYS:        r_ways     <= i_cfg_data;
                    CFG_OFFSET_BITS: r_off_bits <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == {SET_W{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (take) begin
                        if (i_access.operation == OP_FETCH) begin
                            // fetches leave the cache and the stamp alone
                            r_out_valid                <= 1'b1;
                            r_result.access_hits       <= '0;
                            r_result.access_miss       <= 1'b0;
                            r_result.access_eviction   <= 1'b0;
                            r_result.total_hits        <= r_hit_total;
                            r_result.total_misses      <= r_miss_total;
                            r_result.total_evictions   <= r_evict_total;
                        end else begin
                            r_op        <= i_access.operation;
                            r_set       <= n_set;
                            r_tag       <= n_tag;
                            r_stamp_ctr <= r_stamp_ctr + 1'b1;
                            r_state     <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    r_valids <= lk_valids;
                    r_tags   <= lk_tags;
                    r_stamps <= lk_stamps;
                    r_victim <= lk_victim;
                    r_stat   <= lk_stat;
                    r_state  <= S_MINS;
                end
                S_MINS: begin
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    // row goes back to memory this cycle
                    r_hit_total                <= n_hit_total;
                    r_miss_total               <= n_miss_total;
                    r_evict_total              <= n_evict_total;
                    r_out_valid                <= 1'b1;
                    r_result.access_hits       <= n_hits;
                    r_result.access_miss       <= r_stat.miss;
                    r_result.access_eviction   <= r_stat.evict;
                    r_result.total_hits        <= n_hit_total;
                    r_result.total_misses      <= n_miss_total;
                    r_result.total_evictions   <= n_evict_total;
                    r_state                    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

`ifndef NO_ASSERTIONS
    // a cache access returns its word once it has passed S_LOOK, S_MINS and S_PICK
    a_access_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (i_access.operation != OP_FETCH)) |-> ##4 o_valid)
        else $error("cache access result missing");

    // a fetch answers next cycle with no hit, miss or eviction
    a_fetch_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (i_access.operation == OP_FETCH)) |=>
        (o_valid && (o_result.access_hits == 2'd0) && !o_result.access_miss
         && !o_result.access_eviction))
        else $error("fetch changed the counts");

    // an eviction only comes with a miss
    a_evict_needs_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.access_eviction) |-> o_result.access_miss)
        else $error("eviction without miss");

    // totals never go down
    a_totals_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        ((r_hit_total >= $past(r_hit_total)) && (r_miss_total >= $past(r_miss_total))
         && (r_evict_total >= $past(r_evict_total))))
        else $error("running total decreased");
`endif

endmodule

>>> rtl/salru_ram.sv
// ----------------------------------------------------------------------------
// salru_ram
// one-port-write, one-port-read synchronous row memory, registered read data
// ----------------------------------------------------------------------------
module salru_ram #(
    parameter int AW = 6,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [(1 << AW)];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/salru_lookup.sv
// ----------------------------------------------------------------------------
// salru_lookup
// tag compare over one set row and the updated row after hit or fill
// ----------------------------------------------------------------------------
module salru_lookup
    import salru_pkg::*;
#(
    parameter int MAX_WAYS    = DEF_MAX_WAYS,
    parameter int STAMP_WIDTH = DEF_STAMP_WIDTH,
    parameter int WAY_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic [MAX_WAYS-1:0]                  i_valids,
    input  logic [MAX_WAYS-1:0][TAG_W-1:0]       i_tags,
    input  logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] i_stamps,
    input  logic [WAY_W-1:0]                     i_victim,
    input  logic [MAX_WAYS-1:0]                  i_active,
    input  logic [3:0]                           i_ways,
    input  logic [TAG_W-1:0]                     i_tag,
    input  logic [STAMP_WIDTH-1:0]               i_stamp,
    output logic [MAX_WAYS-1:0]                  o_valids,
    output logic [MAX_WAYS-1:0][TAG_W-1:0]       o_tags,
    output logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] o_stamps,
    output logic [WAY_W-1:0]                     o_victim,
    output t_look_stat                           o_stat
);

    logic [WAY_W-1:0] vic;
    logic [WAY_W-1:0] hit_way;
    logic             hit;

    always_comb begin
        // stale victim beyond the active ways falls back to way 0
        vic = (32'(i_victim) >= 32'(i_ways)) ? '0 : i_victim;

        // lowest matching way wins
        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (!hit && i_active[w] && i_valids[w] && (i_tags[w] == i_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end

        o_stat.hit   = hit;
        o_stat.miss  = !hit;
        o_stat.evict = !hit && i_valids[vic];

        for (int w = 0; w < MAX_WAYS; w++) begin
            o_valids[w] = i_valids[w];
            o_tags[w]   = i_tags[w];
            o_stamps[w] = i_stamps[w];
            if (hit && (hit_way == WAY_W'(w))) begin
                o_stamps[w] = i_stamp;
            end else if (!hit && (vic == WAY_W'(w))) begin
                o_valids[w] = 1'b1;
                o_tags[w]   = i_tag;
                o_stamps[w] = i_stamp;
            end
        end

        o_victim = vic;
    end

endmodule

>>> rtl/salru_victim.sv
// ----------------------------------------------------------------------------
// salru_victim
// oldest-stamp search over a set: min tree, registered, then first-match pick
// ----------------------------------------------------------------------------
module salru_victim
    import salru_pkg::*;
#(
    parameter int MAX_WAYS    = DEF_MAX_WAYS,
    parameter int STAMP_WIDTH = DEF_STAMP_WIDTH,
    parameter int WAY_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_load,
    input  logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] i_stamps,
    input  logic [MAX_WAYS-1:0]                  i_active,
    input  logic [WAY_W-1:0]                     i_victim,
    output logic [WAY_W-1:0]                     o_best
);

    localparam int LEAVES = 1 << $clog2(MAX_WAYS);

    logic [2*LEAVES-1:1]                  node_ok;
    logic [2*LEAVES-1:1][STAMP_WIDTH-1:0] node_val;
    logic [STAMP_WIDTH-1:0]               r_min;
    logic [WAY_W-1:0]                     first;
    logic                                 found;

    // min over the active ways
    always_comb begin
        node_ok  = '0;
        node_val = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            node_ok[LEAVES+i]  = i_active[i];
            node_val[LEAVES+i] = i_stamps[i];
        end
        for (int i = LEAVES - 1; i >= 1; i--) begin
            if (node_ok[2*i] && (!node_ok[2*i+1] || (node_val[2*i] <= node_val[2*i+1]))) begin
                node_val[i] = node_val[2*i];
            end else begin
                node_val[i] = node_val[2*i+1];
            end
            node_ok[i] = node_ok[2*i] | node_ok[2*i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_min <= node_val[1];
        end
    end

    // current victim kept unless some way is strictly older
    always_comb begin
        first = '0;
        found = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (!found && i_active[w] && (i_stamps[w] == r_min)) begin
                first = WAY_W'(w);
                found = 1'b1;
            end
        end
        o_best = (r_min != i_stamps[i_victim]) ? first : i_victim;
    end

endmodule

>>> bench/tb_set_assoc_lru_cache_model.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_model
// self-checking bench for the set-associative lru cache model
// ----------------------------------------------------------------------------
// A behavioral copy of the cache (valid, tag and stamp per line, victim way
// per set, saturating totals) predicts the result word of every access word
// at the edge that takes it. A checker compares each strobed result with the
// oldest prediction. Directed tests cover single-way behavior, lru order,
// shrinking associativity and out-of-range settings; random phases then run
// a mix of reused and fresh addresses under many cache geometries.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_model
    import salru_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SETS  = 1 << DEF_MAX_SET_BITS;
    localparam int NUM_LINES = NUM_SETS * DEF_MAX_WAYS;
    localparam int POOL_MAX  = 24;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // dut signals
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_access               i_access;
    logic                  o_valid;
    t_result               o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // mirror of the geometry registers, raw as written
    logic [2:0] geo_set_bits;
    logic [3:0] geo_ways;
    logic [3:0] geo_off_bits;

    // shadow cache contents
    logic                   vld_mem    [NUM_LINES];
    logic [TAG_W-1:0]       tag_mem    [NUM_LINES];
    logic [DEF_STAMP_WIDTH-1:0] stamp_mem [NUM_LINES];
    logic [2:0]             victim_mem [NUM_SETS];
    logic [DEF_STAMP_WIDTH-1:0] stamp_ctr;
    logic [TOTAL_W-1:0]     sum_hits;
    logic [TOTAL_W-1:0]     sum_misses;
    logic [TOTAL_W-1:0]     sum_evicts;

    // predicted result words, oldest first
    t_result exp_results[$];
    int      n_fail;

    // address pool of a random phase, reused to get hits and evictions
    logic [63:0] pool [POOL_MAX];
    int          pool_n;

    set_assoc_lru_cache_model u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_access   (i_access),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // saturating running total
    function automatic logic [TOTAL_W-1:0] total_add(input logic [TOTAL_W-1:0] a,
                                                     input int unsigned b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + (TOTAL_W+1)'(b);
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

    // apply one access word to the shadow cache and return its result word
    function automatic t_result cache_lookup(input t_access acc);
        t_result     res;
        int unsigned set_w;
        int unsigned off_w;
        int unsigned ways;
        int unsigned set_no;
        int unsigned base;
        int unsigned victim;
        int unsigned best;
        int unsigned hits;
        int unsigned miss;
        int unsigned evict;
        int          passes;
        bit          found;
        logic [TAG_W-1:0] tag;
        logic [DEF_STAMP_WIDTH-1:0] best_stamp;
        hits  = 0;
        miss  = 0;
        evict = 0;
        if (acc.operation != OP_FETCH) begin
            // out-of-range settings clamp
            set_w = (geo_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : geo_set_bits;
            off_w = geo_off_bits;
            if (geo_ways == 0)
                ways = 1;
            else if (geo_ways > DEF_MAX_WAYS)
                ways = DEF_MAX_WAYS;
            else
                ways = geo_ways;

            // zero set bits gives set 0 through the empty mask
            set_no = int'((acc.address >> off_w) & ((64'd1 << set_w) - 64'd1));
            tag    = acc.address >> (off_w + set_w);
            base   = set_no * DEF_MAX_WAYS;
            victim = victim_mem[set_no];
            // victim left over from a wider setting
            if (victim >= ways) victim = 0;
            stamp_ctr = stamp_ctr + 1'b1;

            // modify looks the tag up twice
            passes = (acc.operation == OP_MODIFY) ? 2 : 1;
            for (int p = 0; p < passes; p++) begin
                found = 1'b0;
                for (int w = 0; w < ways; w++) begin
                    if (!found && vld_mem[base+w] && tag_mem[base+w] == tag) begin
                        stamp_mem[base+w] = stamp_ctr;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    hits++;
                end else begin
                    miss++;
                    if (vld_mem[base+victim]) evict++;
                    vld_mem[base+victim]   = 1'b1;
                    tag_mem[base+victim]   = tag;
                    stamp_mem[base+victim] = stamp_ctr;
                end
            end

            // next victim: strictly older stamp wins, ties keep the current one
            best       = victim;
            best_stamp = stamp_mem[base+victim];
            for (int w = 0; w < ways; w++) begin
                if (stamp_mem[base+w] < best_stamp) begin
                    best_stamp = stamp_mem[base+w];
                    best       = w;
                end
            end
            victim_mem[set_no] = best[2:0];

            sum_hits   = total_add(sum_hits, hits);
            sum_misses = total_add(sum_misses, miss);
            sum_evicts = total_add(sum_evicts, evict);
        end
        res.access_hits     = hits[1:0];
        res.access_miss     = miss[0];
        res.access_eviction = evict[0];
        res.total_hits      = sum_hits;
        res.total_misses    = sum_misses;
        res.total_evictions = sum_evicts;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_w;
        if (i_rst_n && o_valid) begin
            if (exp_results.size() == 0) begin
                $error("result word with no access pending");
                n_fail++;
            end else begin
                exp_w = exp_results.pop_front();
                if (o_result.access_hits !== exp_w.access_hits) begin
                    $error("access_hits: expected %0d, actual %0d",
                           exp_w.access_hits, o_result.access_hits);
                    n_fail++;
                end
                if (o_result.access_miss !== exp_w.access_miss) begin
                    $error("access_miss: expected %0d, actual %0d",
                           exp_w.access_miss, o_result.access_miss);
                    n_fail++;
                end
                if (o_result.access_eviction !== exp_w.access_eviction) begin
                    $error("access_eviction: expected %0d, actual %0d",
                           exp_w.access_eviction, o_result.access_eviction);
                    n_fail++;
                end
                if (o_result.total_hits !== exp_w.total_hits) begin
                    $error("total_hits: expected %0d, actual %0d",
                           exp_w.total_hits, o_result.total_hits);
                    n_fail++;
                end
                if (o_result.total_misses !== exp_w.total_misses) begin
                    $error("total_misses: expected %0d, actual %0d",
                           exp_w.total_misses, o_result.total_misses);
                    n_fail++;
                end
                if (o_result.total_evictions !== exp_w.total_evictions) begin
                    $error("total_evictions: expected %0d, actual %0d",
                           exp_w.total_evictions, o_result.total_evictions);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // present one access word and hold it until the block takes it
    task automatic issue_access(input logic [1:0] op, input logic [63:0] addr);
        t_access acc;
        acc.operation = op;
        acc.address   = addr;
        @(negedge i_clk);
        start    <= 1'b1;
        i_access <= acc;
        // taken at the first edge with busy low
        do @(posedge i_clk); while (busy);
        exp_results.push_back(cache_lookup(acc));
    endtask

    // drop start for a pause whose length is given by n
    task automatic idle_for(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // mostly back to back, sometimes a short pause, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    // let every pending result come out, then settle before a register write
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (exp_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // one register write, mirrored into the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_SET_BITS:    geo_set_bits = data[2:0];
            CFG_WAYS:        geo_ways     = data;
            CFG_OFFSET_BITS: geo_off_bits = data;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] set_bits,
                                input logic [CFG_DATA_W-1:0] ways,
                                input logic [CFG_DATA_W-1:0] off_bits);
        wait_drained();
        write_reg(CFG_SET_BITS, set_bits);
        write_reg(CFG_WAYS, ways);
        write_reg(CFG_OFFSET_BITS, off_bits);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset geometry: one set, one way, byte blocks
    task automatic test_single_way();
        issue_access(OP_FETCH, 64'd0);
        issue_access(OP_LOAD, 64'd0);              // cold miss
        issue_access(OP_LOAD, 64'd0);              // hit
        issue_access(OP_STORE, {64{1'b1}});        // miss with eviction
        issue_access(OP_MODIFY, {64{1'b1}});       // two hits
        issue_access(OP_MODIFY, 64'd0);            // miss, evict, then hit
        issue_access(OP_FETCH, {64{1'b1}});
    endtask

    // four sets of four ways with 16-byte blocks; fill set 0 and roll it over
    task automatic test_lru_order();
        set_geometry(4'd2, 4'd4, 4'd4);
        for (int t = 1; t <= 4; t++)
            issue_access(OP_LOAD, 64'(t) << 6);
        issue_access(OP_LOAD, 64'd5 << 6);          // evicts the oldest tag
        issue_access(OP_LOAD, (64'd2 << 6) | 64'hf); // hit, offset ignored
        issue_access(OP_STORE, 64'd1 << 6);         // tag 1 was evicted
    endtask

    // shrink the ways under a live set, then out-of-range settings
    task automatic test_config_edges();
        // victim recorded beyond the new way count falls back to way 0
        set_geometry(4'd2, 4'd4, 4'd4);
        write_reg(CFG_WAYS, 4'd2);
        issue_access(OP_LOAD, 64'd9 << 6);
        issue_access(OP_LOAD, 64'd5 << 6);
        // set bits above the maximum, zero ways, largest offset, unused index
        set_geometry(4'd7, 4'd0, 4'd15);
        write_reg(CFG_UNUSED, 4'd15);
        issue_access(OP_LOAD, {64{1'b1}});
        issue_access(OP_STORE, 64'h8000_0000_0000_0000);
        issue_access(OP_MODIFY, {64{1'b1}});
        // widest legal geometry, ways above the maximum
        set_geometry(4'd6, 4'd15, 4'd12);
        issue_access(OP_MODIFY, 64'h0000_0000_0003_f000);
        issue_access(OP_MODIFY, 64'h0000_0000_0003_f000);
        issue_access(OP_FETCH, 64'h0000_0000_0003_f000);
    endtask

    // random geometries, each with a pool of reused addresses plus noise
    task automatic test_random_traffic();
        logic [3:0]  sb;
        logic [3:0]  wy;
        logic [3:0]  ob;
        logic [63:0] addr;
        logic [63:0] mask;
        int          eff_s;
        bit          no_gaps;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin sb = 4'd0; wy = 4'd1;  ob = 4'd0;  end
                1: begin sb = 4'd6; wy = 4'd8;  ob = 4'd12; end
                2: begin sb = 4'd7; wy = 4'd15; ob = 4'd15; end
                3: begin sb = 4'd0; wy = 4'd0;  ob = 4'd13; end
                4: begin sb = 4'd1; wy = 4'd8;  ob = 4'd0;  end
                default: begin
                    sb = 4'($urandom_range(0, 15));
                    wy = 4'($urandom_range(0, 15));
                    ob = 4'($urandom_range(0, 15));
                end
            endcase
            set_geometry(sb, wy, ob);
            if ($urandom_range(0, 1)) write_reg(CFG_UNUSED, 4'($urandom));

            // pool entries, each packed with even odds into one of the two lowest sets
            eff_s  = (geo_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : geo_set_bits;
            mask   = ((64'd1 << eff_s) - 64'd1) << geo_off_bits;
            pool_n = $urandom_range(2, POOL_MAX);
            for (int k = 0; k < pool_n; k++) begin
                pool[k] = {$urandom, $urandom};
                if ($urandom_range(0, 1))
                    pool[k] = (pool[k] & ~mask) | ((64'(k % 2) << geo_off_bits) & mask);
            end

            // some phases run with no pauses at all
            no_gaps = ($urandom_range(0, 9) < 3);
            for (int n = 0; n < 200; n++) begin
                if ($urandom_range(0, 99) < 85) begin
                    addr = pool[$urandom_range(0, pool_n - 1)];
                    mask = (64'd1 << geo_off_bits) - 64'd1;
                    addr = (addr & ~mask) | ({$urandom, $urandom} & mask);
                end else begin
                    addr = {$urandom, $urandom};
                end
                issue_access(2'($urandom_range(0, 3)), addr);
                if (!no_gaps) idle_for(pick_gap());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        // shadow cache matches the block after reset
        for (int i = 0; i < NUM_LINES; i++) begin
            vld_mem[i]   = 1'b0;
            tag_mem[i]   = '0;
            stamp_mem[i] = '0;
        end
        for (int i = 0; i < NUM_SETS; i++) victim_mem[i] = '0;
        stamp_ctr    = '0;
        sum_hits     = '0;
        sum_misses   = '0;
        sum_evicts   = '0;
        geo_set_bits = 3'd0;
        geo_ways     = 4'd1;
        geo_off_bits = 4'd0;
        n_fail       = 0;

        // all inputs known from time zero
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_access   = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // the clearing sweep shows as busy, which issue_access waits out
        test_single_way();
        test_lru_order();
        test_config_edges();
        test_random_traffic();

        // everything accepted: wait for the tail of results, then settle
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (n_fail == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
rtl/salru_pkg.sv
rtl/salru_ram.sv
rtl/salru_lookup.sv
rtl/salru_victim.sv
rtl/set_assoc_lru_cache_model.sv
bench/tb_set_assoc_lru_cache_model.sv
